FILE: sv/timestamp_priority_queue_unit_defines.svh
// Assertion macros for the timestamp priority queue unit.
// Each macro checks on the rising edge of clk_i, held off while rst_ni is low.
`ifndef TIMESTAMP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define TIMESTAMP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpq assertion failed");
// Next-cycle implication.
`define TPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpq assertion failed");
`else
`define TPQ_ASSERT_NOW(label, ante, cons)
`define TPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/tpq_pkg.sv
package tpq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned STAMP_W = 31;
  localparam int unsigned CNT_W   = 5;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

endpackage

FILE: sv/timestamp_priority_queue_unit.sv
// Sorted request queue, entries in one single-port-read, single-port-write RAM.
// An insert walks the held entries down from the tail, a remove walks them up from the head;
// the walk reads one entry per cycle through the RAM's registered read port.
// Items are taken one at a time, each finished before another is accepted; the next item
// is accepted the cycle after the result is registered, later while the result side stalls.
// Reset: async, active low; clears count, limit to 16 and handshakes; entry RAM left as is.
`include "timestamp_priority_queue_unit_defines.svh"

module timestamp_priority_queue_unit #(
  parameter int unsigned ID_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpq_pkg::CNT_W-1:0]     cfg_data_i,
  // request items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [tpq_pkg::STAMP_W-1:0]   clock_stamp_i,
  input  logic [ID_BITS-1:0]            process_id_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tpq_pkg::status_e              status_o,
  output logic [tpq_pkg::CNT_W-1:0]     entry_count_o,
  output logic                          head_valid_o,
  output logic [tpq_pkg::STAMP_W-1:0]   head_stamp_o,
  output logic [ID_BITS-1:0]            head_id_o
);

  import tpq_pkg::*;

  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENTRY_W = STAMP_W + ID_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        idx_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     cap_q;
  status_e              status_q;
  logic [STAMP_W-1:0]   new_stamp_q;
  logic [ID_BITS-1:0]   new_id_q;
  logic [STAMP_W-1:0]   head_stamp_q;
  logic [ID_BITS-1:0]   head_id_q;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [CNT_W-1:0]     out_count_q;
  logic                 out_head_valid_q;
  logic [STAMP_W-1:0]   out_head_stamp_q;
  logic [ID_BITS-1:0]   out_head_id_q;

  // entry RAM
  logic [ENTRY_W-1:0]   mem_q [DEPTH];
  logic [ENTRY_W-1:0]   rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  logic                 in_fire;
  logic                 is_full;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [ID_BITS-1:0]   rd_id;
  logic                 rd_less;
  logic                 rd_match;
  logic                 scan_last;
  logic                 shift_last;
  logic                 out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // refuse inserts at the smaller of the limit and the RAM depth
  assign is_full = (count_q >= cap_q) || (32'(count_q) >= DEPTH);

  // split and compare the entry that the last read returned
  assign rd_stamp   = rdata_q[ENTRY_W-1:ID_BITS];
  assign rd_id      = rdata_q[ID_BITS-1:0];
  assign rd_less    = (rd_stamp < new_stamp_q) ||
                      ((rd_stamp == new_stamp_q) && (rd_id < new_id_q));
  assign rd_match   = (rd_id == new_id_q);
  assign scan_last  = (32'(idx_q) + 32'd1) == 32'(count_q);
  assign shift_last = (32'(idx_q) + 32'd2) == 32'(count_q);

  // drive RAM ports for the current walk step
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (func_i == FUNC_INSERT) begin
            if (!is_full && (count_q == '0)) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = {clock_stamp_i, process_id_i};
            end else if (!is_full) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(count_q - CNT_W'(1));
            end
          end else if (count_q != '0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        if (rd_less) begin
          mem_wdata = {new_stamp_q, new_id_q};
        end else if (idx_q != AW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q - AW'(2);
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {new_stamp_q, new_id_q};
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q + AW'(1);
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_re    = 1'b1;
        mem_raddr = idx_q + AW'(2);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // write and read the entry RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // sequence the walk, hold the count, head copy and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      idx_q            <= '0;
      count_q          <= '0;
      cap_q            <= CAP_RESET;
      status_q         <= ST_DONE;
      new_stamp_q      <= '0;
      new_id_q         <= '0;
      head_stamp_q     <= '0;
      head_id_q        <= '0;
      out_valid_q      <= 1'b0;
      out_status_q     <= ST_DONE;
      out_count_q      <= '0;
      out_head_valid_q <= 1'b0;
      out_head_stamp_q <= '0;
      out_head_id_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      // drop the taken result unless the finish step loads the next one
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            new_stamp_q <= clock_stamp_i;
            new_id_q    <= process_id_i;
            if (func_i == FUNC_INSERT) begin
              if (is_full) begin
                status_q <= ST_FULL;
                state_q  <= S_FIN;
              end else if (count_q == '0) begin
                status_q     <= ST_DONE;
                count_q      <= CNT_W'(1);
                head_stamp_q <= clock_stamp_i;
                head_id_q    <= process_id_i;
                state_q      <= S_FIN;
              end else begin
                status_q <= ST_DONE;
                idx_q    <= AW'(count_q);
                state_q  <= S_INS;
              end
            end else begin
              if (count_q == '0) begin
                status_q <= ST_NOT_FOUND;
                state_q  <= S_FIN;
              end else begin
                status_q <= ST_DONE;
                idx_q    <= '0;
                state_q  <= S_SCAN;
              end
            end
          end
        end
        S_INS: begin
          // place behind a smaller entry, else move this one up a slot
          if (rd_less) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_FIN;
          end else if (idx_q == AW'(1)) begin
            state_q <= S_PUT;
          end else begin
            idx_q <= idx_q - AW'(1);
          end
        end
        S_PUT: begin
          head_stamp_q <= new_stamp_q;
          head_id_q    <= new_id_q;
          count_q      <= count_q + CNT_W'(1);
          state_q      <= S_FIN;
        end
        S_SCAN: begin
          if (rd_match && scan_last) begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_FIN;
          end else if (rd_match) begin
            state_q <= S_SHIFT;
          end else if (scan_last) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_FIN;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_SHIFT: begin
          // move the next entry down; promote it when it lands at the head
          if (idx_q == '0) begin
            head_stamp_q <= rd_stamp;
            head_id_q    <= rd_id;
          end
          if (shift_last) begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            out_status_q     <= status_q;
            out_count_q      <= count_q;
            out_head_valid_q <= (count_q != '0);
            out_head_stamp_q <= (count_q != '0) ? head_stamp_q : '0;
            out_head_id_q    <= (count_q != '0) ? head_id_q : '0;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign head_valid_o  = out_head_valid_q;
  assign head_stamp_o  = out_head_stamp_q;
  assign head_id_o     = out_head_id_q;

  // a walk step never writes the entry it is reading
  `TPQ_ASSERT_NOW(a_no_rw_alias, mem_we && mem_re, mem_waddr != mem_raddr)
  // head presence follows the reported count
  `TPQ_ASSERT_NOW(a_head_vs_count, out_valid_o, head_valid_o == (entry_count_o != '0))
  // a refused insert reports a count at or above the limit or the RAM depth
  `TPQ_ASSERT_NOW(a_full_at_limit, out_valid_o && (status_o == ST_FULL),
                  (entry_count_o >= cap_q) || (32'(entry_count_o) >= DEPTH))
  // a new result is only loaded out of the finish step
  `TPQ_ASSERT_NEXT(a_result_from_fin, !out_valid_o && (state_q != S_FIN), !out_valid_o)

endmodule
